// File: sv/ppg_heartbeat_detector_top_defines.svh
// assertion macros for the rtl controller
`ifndef PPG_HEARTBEAT_DETECTOR_TOP_DEFINES_SVH
`define PPG_HEARTBEAT_DETECTOR_TOP_DEFINES_SVH

// same-cycle implication, clocked on i_clk, off during reset
`define PPG_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("ppg assertion failed");

// next-cycle implication
`define PPG_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("ppg assertion failed");

`endif

// File: sv/ppg_pkg.sv
package ppg_pkg;

    localparam int SAMPLE_WIDTH_DEF = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 18;
    localparam int DIV_W      = 25;
    localparam int SS_W       = 26;
    localparam int HYST_W     = 13;
    localparam int OUT_W      = 24;

    localparam logic [CFG_IDX_W-1:0] REG_FINGER_ON  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FINGER_OFF = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PRIME      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_HYST_MIN   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_HYST_MAX   = 3'd6;

    localparam logic [17:0] FINGER_ON_RST  = 18'd20000;
    localparam logic [17:0] FINGER_OFF_RST = 18'd5000;
    localparam logic [15:0] TIMEOUT_RST    = 16'd1800;
    localparam logic [4:0]  PRIME_RST      = 5'd20;
    localparam logic [15:0] OFFSET_RST     = 16'd200;
    localparam logic [11:0] HYST_MIN_RST   = 12'd35;
    localparam logic [11:0] HYST_MAX_RST   = 12'd120;

    localparam logic [16:0] ONE_Q16 = 17'd65536;
    localparam logic [16:0] K99     = 17'd64881;
    localparam logic [16:0] K95     = 17'd62259;
    localparam logic [16:0] K60     = 17'd39322;
    localparam logic [16:0] K20     = 17'd13107;
    localparam logic [16:0] K05     = 17'd3277;

    localparam logic signed [31:0] VALLEY_FILL = 32'sh007FFF00;
    localparam logic [15:0] BPM_NUM   = 16'd60000;
    localparam logic [4:0]  COUNT_CAP = 5'd25;
    // divide by fifteen as a multiply by ceil(2^29 / 15), exact below 2^25
    localparam logic [25:0] HYST_RECIP = 26'd35791395;
    localparam int          HYST_SHIFT = 29;

    localparam logic [1:0] EV_NONE  = 2'd0;
    localparam logic [1:0] EV_BEAT  = 2'd1;
    localparam logic [1:0] EV_GONE  = 2'd2;
    localparam logic [1:0] EV_FAULT = 2'd3;

    localparam logic [3:0] OP_NOP       = 4'd0;
    localparam logic [3:0] OP_LOAD      = 4'd1;
    localparam logic [3:0] OP_PRE       = 4'd2;
    localparam logic [3:0] OP_MUL_A     = 4'd3;
    localparam logic [3:0] OP_MUL_B     = 4'd4;
    localparam logic [3:0] OP_WRITE     = 4'd5;
    localparam logic [3:0] OP_SHIFT_MUL = 4'd6;
    localparam logic [3:0] OP_SHIFT_CMP = 4'd7;
    localparam logic [3:0] OP_HOLD      = 4'd8;
    localparam logic [3:0] OP_DIV_H     = 4'd9;
    localparam logic [3:0] OP_HYST      = 4'd10;
    localparam logic [3:0] OP_BEAT      = 4'd11;
    localparam logic [3:0] OP_DIV_B     = 4'd12;
    localparam logic [3:0] OP_BPM       = 4'd13;
    localparam logic [3:0] OP_EMIT      = 4'd14;

    localparam logic [2:0] T_BASE  = 3'd0;
    localparam logic [2:0] T_HP    = 3'd1;
    localparam logic [2:0] T_LP    = 3'd2;
    localparam logic [2:0] T_SPK60 = 3'd3;
    localparam logic [2:0] T_SVL60 = 3'd4;
    localparam logic [2:0] T_SVL99 = 3'd5;
    localparam logic [2:0] T_SPK99 = 3'd6;

    typedef struct packed {
        logic [3:0] op;
        logic [2:0] tgt;
    } t_cmd;

    typedef struct packed {
        logic filter;
        logic pto;
        logic vto;
        logic cond;
        logic rise;
        logic div_busy;
    } t_status;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sd2147483647) begin
            r = 32'sh7FFFFFFF;
        end else if (v < -64'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

// File: sv/ppg_ctrl.sv
`include "ppg_heartbeat_detector_top_defines.svh"

module ppg_ctrl
    import ppg_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_s_tvalid,
    output logic    o_s_tready,
    output logic    o_m_tvalid,
    input  logic    i_m_tready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_PRE   = 5'd1;
    localparam logic [4:0] S_MA    = 5'd2;
    localparam logic [4:0] S_MB    = 5'd3;
    localparam logic [4:0] S_MW    = 5'd4;
    localparam logic [4:0] S_SMUL  = 5'd5;
    localparam logic [4:0] S_SCMP  = 5'd6;
    localparam logic [4:0] S_HOLD  = 5'd7;
    localparam logic [4:0] S_DIVH  = 5'd8;
    localparam logic [4:0] S_WDIVH = 5'd9;
    localparam logic [4:0] S_HYST  = 5'd10;
    localparam logic [4:0] S_BEAT  = 5'd11;
    localparam logic [4:0] S_RISE  = 5'd12;
    localparam logic [4:0] S_DIVB  = 5'd13;
    localparam logic [4:0] S_WDIVB = 5'd14;
    localparam logic [4:0] S_BPM   = 5'd15;
    localparam logic [4:0] S_OUT   = 5'd16;

    logic [4:0] r_state, n_state;
    logic [2:0] r_tgt, n_tgt;
    logic       r_m_valid, n_m_valid;

    always_comb begin
        n_state   = r_state;
        n_tgt     = r_tgt;
        n_m_valid = r_m_valid & ~i_m_tready;
        o_cmd.op  = OP_NOP;
        o_cmd.tgt = r_tgt;
        case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    o_cmd.op = OP_LOAD;
                    n_state  = S_PRE;
                end
            end
            S_PRE: begin
                o_cmd.op = OP_PRE;
                if (i_status.filter) begin
                    n_state = S_MA;
                    n_tgt   = T_BASE;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_MA: begin
                o_cmd.op = OP_MUL_A;
                n_state  = S_MB;
            end
            S_MB: begin
                o_cmd.op = OP_MUL_B;
                n_state  = S_MW;
            end
            S_MW: begin
                o_cmd.op = OP_WRITE;
                case (r_tgt)
                    T_BASE: begin
                        n_state = S_MA;
                        n_tgt   = T_HP;
                    end
                    T_HP: begin
                        n_state = S_MA;
                        n_tgt   = T_LP;
                    end
                    T_LP:    n_state = S_SMUL;
                    T_SPK60: begin
                        if (i_status.vto) begin
                            n_state = S_MA;
                            n_tgt   = T_SVL60;
                        end else begin
                            n_state = S_DIVH;
                        end
                    end
                    T_SVL60: n_state = S_DIVH;
                    T_SVL99: n_state = S_BEAT;
                    default: n_state = S_RISE;
                endcase
            end
            S_SMUL: begin
                o_cmd.op = OP_SHIFT_MUL;
                n_state  = S_SCMP;
            end
            S_SCMP: begin
                o_cmd.op = OP_SHIFT_CMP;
                n_state  = S_HOLD;
            end
            S_HOLD: begin
                o_cmd.op = OP_HOLD;
                if (i_status.pto) begin
                    n_state = S_MA;
                    n_tgt   = T_SPK60;
                end else if (i_status.vto) begin
                    n_state = S_MA;
                    n_tgt   = T_SVL60;
                end else begin
                    n_state = S_DIVH;
                end
            end
            S_DIVH: begin
                o_cmd.op = OP_DIV_H;
                n_state  = S_WDIVH;
            end
            S_WDIVH: begin
                if (!i_status.div_busy) begin
                    n_state = S_HYST;
                end
            end
            S_HYST: begin
                o_cmd.op = OP_HYST;
                n_state  = S_MA;
                n_tgt    = i_status.cond ? T_SVL99 : T_SPK99;
            end
            S_BEAT: begin
                o_cmd.op = OP_BEAT;
                n_state  = S_RISE;
            end
            S_RISE: begin
                n_state = i_status.rise ? S_DIVB : S_OUT;
            end
            S_DIVB: begin
                o_cmd.op = OP_DIV_B;
                n_state  = S_WDIVB;
            end
            S_WDIVB: begin
                if (!i_status.div_busy) begin
                    n_state = S_BPM;
                end
            end
            S_BPM: begin
                o_cmd.op = OP_BPM;
                n_state  = S_OUT;
            end
            S_OUT: begin
                if (!r_m_valid || i_m_tready) begin
                    o_cmd.op  = OP_EMIT;
                    n_m_valid = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_tgt     <= T_BASE;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_tgt     <= n_tgt;
            r_m_valid <= n_m_valid;
        end
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_m_valid;

    `PPG_ASSERT_NXT(a_accept_to_pre, r_state == S_IDLE && i_s_tvalid, r_state == S_PRE)
    `PPG_ASSERT_NXT(a_divh_done, r_state == S_WDIVH && !i_status.div_busy, r_state == S_HYST)
    `PPG_ASSERT_NXT(a_emit_valid, o_cmd.op == OP_EMIT, o_m_tvalid && r_state == S_IDLE)
    `PPG_ASSERT_IMP(a_busy_waits, i_status.div_busy, r_state == S_WDIVH || r_state == S_WDIVB)

endmodule

// File: sv/ppg_dp.sv
module ppg_dp
    import ppg_pkg::*;
#(
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic [SAMPLE_WIDTH-1:0] i_red_level,
    input  logic [SAMPLE_WIDTH-1:0] i_ir_one_level,
    input  logic [SAMPLE_WIDTH-1:0] i_ir_two_level,
    input  logic [31:0]             i_now_ms,
    input  logic                    i_cfg_valid,
    input  logic [CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [CFG_DATA_W-1:0]   i_cfg_data,
    input  t_cmd                    i_cmd,
    output t_status                 o_status,
    output logic [OUT_W-1:0]        o_data
);

    localparam int IRW  = SAMPLE_WIDTH + 1;
    localparam int TW   = SAMPLE_WIDTH + 2;
    localparam int CW   = (TW > 18) ? TW : 18;
    localparam int AW   = (SAMPLE_WIDTH + 10 > 33) ? SAMPLE_WIDTH + 10 : 33;
    localparam int PW   = AW + 18;
    localparam int ACCW = PW + 1;
    localparam int DCW  = $clog2(DIV_W + 1);
    localparam int HQW  = DIV_W + HYST_SHIFT;
    localparam logic signed [ACCW-1:0] HALF8  = ACCW'(128);
    localparam logic signed [ACCW-1:0] HALF16 = ACCW'(32768);

    // configuration
    logic [17:0] r_on, r_off;
    logic [15:0] r_timeout, r_offset;
    logic [4:0]  r_prime;
    logic [11:0] r_hmin, r_hmax;

    // sample
    logic [SAMPLE_WIDTH-1:0] r_red, r_ir1, r_ir2;
    logic [31:0]             r_now;

    // detector state
    logic [TW-1:0]            r_prev_total;
    logic [4:0]               r_finger;
    logic signed [31:0]       r_base, r_hp, r_lp, r_pk, r_vl, r_spk, r_svl;
    logic signed [HYST_W-1:0] r_hyst;
    logic signed [SS_W-1:0]   r_ss;
    logic                     r_beat_now, r_beat_before;
    logic [31:0]              r_pk_time, r_vl_time, r_last_beat;

    // work registers
    logic signed [ACCW-1:0] r_acc;
    logic                   r_cond, r_gap_zero;
    logic [1:0]             r_event;
    logic [15:0]            r_bpm;
    logic [31:0]            r_div_rem, r_div_den;
    logic [DIV_W-1:0]       r_div_q;
    logic [DCW-1:0]         r_div_cnt;
    logic [OUT_W-1:0]       r_out;

    // front-end arithmetic
    logic [TW-1:0]  total;
    logic [IRW-1:0] irsum;
    logic [CW-1:0]  tot_c, on_c, off_c;
    logic           zero, set_one, prime, below_off, above_on;
    logic [5:0]     f_inc;
    logic [4:0]     fing_new;

    assign zero      = (r_red == '0) && (r_ir1 == '0) && (r_ir2 == '0);
    assign total     = TW'(r_red) + TW'(r_ir1) + TW'(r_ir2);
    assign irsum     = IRW'(r_ir1) + IRW'(r_ir2);
    assign tot_c     = CW'(total);
    assign on_c      = CW'(r_on);
    assign off_c     = CW'(r_off);
    assign set_one   = (CW'(r_prev_total) < on_c) && (tot_c > on_c);
    assign f_inc     = (set_one ? 6'd1 : {1'b0, r_finger}) + 6'd1;
    assign fing_new  = (f_inc > {1'b0, COUNT_CAP}) ? COUNT_CAP : f_inc[4:0];
    assign prime     = fing_new < r_prime;
    assign below_off = tot_c < off_c;
    assign above_on  = tot_c > on_c;

    // shared multiplier operands
    logic signed [AW-1:0]  x_val, x_op, m_a;
    logic signed [31:0]    d_val, s_op, sm_res;
    logic [16:0]           coef;
    logic signed [17:0]    m_b;
    logic signed [PW-1:0]  prod;

    assign x_val  = AW'({1'b0, irsum, 8'd0});
    assign d_val  = sat32(64'(x_val) - 64'(r_base));
    assign sm_res = sat32(64'((r_acc + HALF16) >>> 16));

    always_comb begin
        case (i_cmd.tgt)
            T_BASE: begin
                x_op = x_val;
                s_op = r_base;
                coef = K99;
            end
            T_HP: begin
                x_op = AW'(d_val);
                s_op = r_hp;
                coef = K20;
            end
            T_LP: begin
                x_op = AW'(d_val);
                s_op = r_lp;
                coef = K95;
            end
            T_SPK60: begin
                x_op = AW'(r_pk);
                s_op = r_spk;
                coef = K60;
            end
            T_SVL60: begin
                x_op = AW'(r_vl);
                s_op = r_svl;
                coef = K60;
            end
            T_SVL99: begin
                x_op = AW'(r_vl);
                s_op = r_svl;
                coef = K99;
            end
            default: begin
                x_op = AW'(r_pk);
                s_op = r_spk;
                coef = K99;
            end
        endcase
    end

    always_comb begin
        case (i_cmd.op)
            OP_MUL_A: begin
                m_a = x_op;
                m_b = {1'b0, ONE_Q16 - coef};
            end
            OP_MUL_B: begin
                m_a = AW'(s_op);
                m_b = {1'b0, coef};
            end
            default: begin
                m_a = AW'(r_ss);
                m_b = {1'b0, K05};
            end
        endcase
    end

    assign prod = m_a * m_b;

    // beat compare
    logic signed [ACCW-1:0] shift_term;
    logic signed [34:0]     shifted, hp2;

    assign shift_term = (r_acc + HALF8) >>> 8;
    assign shifted    = 35'(r_lp) - 35'(shift_term);
    assign hp2        = 35'(r_hp) + 35'($signed({r_hyst, 8'd0}));

    // peak and valley holds
    logic signed [31:0] pk_new, vl_new;
    logic               pto, vto;

    assign pk_new = (r_pk == 0 || r_hp > r_pk) ? r_hp : r_pk;
    assign vl_new = (r_vl == 0 || r_hp < r_vl) ? r_hp : r_vl;
    assign pto    = (r_now - r_pk_time) > {16'd0, r_timeout};
    assign vto    = (r_now - r_vl_time) > {16'd0, r_timeout};

    // signal size from smoothed peak and valley
    logic signed [32:0]   diff;
    logic [32:0]          diff_mag;
    logic [DIV_W-1:0]     diff_q;
    logic signed [SS_W-1:0] ss_new;

    assign diff     = 33'(r_spk) - 33'(r_svl);
    assign diff_mag = diff[32] ? 33'(-diff) : 33'(diff);
    assign diff_q   = diff_mag[32:8];
    assign ss_new   = diff[32] ? -$signed({1'b0, diff_q}) : $signed({1'b0, diff_q});

    // hysteresis clamp
    logic [SS_W-1:0]          ss_mag;
    logic [HQW-1:0]           hq_prod;
    logic signed [DIV_W:0]    hq, h_s;
    logic [11:0]              hc;
    logic signed [HYST_W-1:0] hyst_new;

    assign ss_mag  = r_ss[SS_W-1] ? SS_W'(-r_ss) : SS_W'(r_ss);
    assign hq_prod = HQW'(ss_mag[DIV_W-1:0]) * HQW'(HYST_RECIP);
    assign hq      = $signed({1'b0, r_div_q});
    assign h_s     = r_ss[SS_W-1] ? -hq : hq;

    always_comb begin
        if (h_s < $signed((DIV_W + 1)'({1'b0, r_hmin}))) begin
            hc = r_hmin;
        end else if (h_s > $signed((DIV_W + 1)'({1'b0, r_hmax}))) begin
            hc = r_hmax;
        end else begin
            hc = h_s[11:0];
        end
    end

    assign hyst_new = r_cond ? -$signed({1'b0, hc}) : $signed({1'b0, hc});

    // radix-2 restoring divider
    logic [32:0] div_sh;
    logic        div_ge;
    logic [31:0] gap;

    assign div_sh = {r_div_rem, r_div_q[DIV_W-1]};
    assign div_ge = div_sh >= {1'b0, r_div_den};
    assign gap    = r_now - r_last_beat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div_cnt <= '0;
        end else if (i_cmd.op == OP_DIV_B) begin
            r_div_cnt <= DCW'(DIV_W);
        end else if (r_div_cnt != '0) begin
            r_div_cnt <= r_div_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_DIV_H) begin
            r_div_q <= hq_prod[HQW-1:HYST_SHIFT];
        end else if (i_cmd.op == OP_DIV_B) begin
            r_div_rem <= '0;
            r_div_q   <= DIV_W'(BPM_NUM);
            r_div_den <= gap;
        end else if (r_div_cnt != '0) begin
            r_div_rem <= div_ge ? 32'(div_sh - {1'b0, r_div_den}) : div_sh[31:0];
            r_div_q   <= {r_div_q[DIV_W-2:0], div_ge};
        end
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_on      <= FINGER_ON_RST;
            r_off     <= FINGER_OFF_RST;
            r_timeout <= TIMEOUT_RST;
            r_prime   <= PRIME_RST;
            r_offset  <= OFFSET_RST;
            r_hmin    <= HYST_MIN_RST;
            r_hmax    <= HYST_MAX_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_FINGER_ON:  r_on      <= i_cfg_data;
                REG_FINGER_OFF: r_off     <= i_cfg_data;
                REG_TIMEOUT:    r_timeout <= i_cfg_data[15:0];
                REG_PRIME:      r_prime   <= i_cfg_data[4:0];
                REG_OFFSET:     r_offset  <= i_cfg_data[15:0];
                REG_HYST_MIN:   r_hmin    <= i_cfg_data[11:0];
                REG_HYST_MAX:   r_hmax    <= i_cfg_data[11:0];
                default: ;
            endcase
        end
    end

    // sample and work registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_LOAD) begin
            r_red <= i_red_level;
            r_ir1 <= i_ir_one_level;
            r_ir2 <= i_ir_two_level;
            r_now <= i_now_ms;
        end
        case (i_cmd.op)
            OP_MUL_A:     r_acc <= ACCW'(prod);
            OP_MUL_B:     r_acc <= r_acc + ACCW'(prod);
            OP_SHIFT_MUL: r_acc <= ACCW'(prod);
            OP_SHIFT_CMP: r_cond <= hp2 < shifted;
            OP_DIV_B:     r_gap_zero <= (gap == '0);
            OP_EMIT:      r_out <= OUT_W'({r_beat_now, r_bpm, r_event});
            default: ;
        endcase
    end

    // detector state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_total  <= '0;
            r_finger      <= '0;
            r_base        <= '0;
            r_hp          <= '0;
            r_lp          <= '0;
            r_hyst        <= '0;
            r_pk          <= '0;
            r_vl          <= '0;
            r_spk         <= '0;
            r_svl         <= '0;
            r_ss          <= '0;
            r_beat_now    <= 1'b0;
            r_beat_before <= 1'b0;
            r_pk_time     <= '0;
            r_vl_time     <= '0;
            r_last_beat   <= '0;
            r_event       <= EV_NONE;
            r_bpm         <= '0;
        end else begin
            case (i_cmd.op)
                OP_PRE: begin
                    r_bpm <= '0;
                    if (zero) begin
                        r_prev_total  <= '0;
                        r_finger      <= '0;
                        r_base        <= '0;
                        r_hp          <= '0;
                        r_lp          <= '0;
                        r_hyst        <= '0;
                        r_pk          <= '0;
                        r_vl          <= '0;
                        r_spk         <= '0;
                        r_svl         <= '0;
                        r_ss          <= '0;
                        r_beat_now    <= 1'b0;
                        r_beat_before <= 1'b0;
                        r_pk_time     <= '0;
                        r_vl_time     <= '0;
                        r_last_beat   <= '0;
                        r_event       <= EV_FAULT;
                    end else begin
                        if (r_pk_time == '0) begin
                            r_pk_time <= r_now;
                        end
                        if (r_vl_time == '0) begin
                            r_vl_time <= r_now;
                        end
                        r_prev_total <= total;
                        r_finger     <= fing_new;
                        if (prime) begin
                            r_base  <= sat32($signed(64'(total) - 64'(r_offset)) <<< 8);
                            r_event <= EV_NONE;
                        end else begin
                            r_event <= below_off ? EV_GONE : EV_NONE;
                        end
                    end
                end
                OP_WRITE: begin
                    case (i_cmd.tgt)
                        T_BASE: r_base <= sm_res;
                        T_HP:   r_hp   <= sm_res;
                        T_LP:   r_lp   <= sm_res;
                        T_SVL60: begin
                            r_svl     <= sm_res;
                            r_vl      <= '0;
                            r_vl_time <= r_now;
                        end
                        T_SVL99: r_svl <= sm_res;
                        default: begin
                            r_spk     <= sm_res;
                            r_pk      <= '0;
                            r_pk_time <= r_now;
                        end
                    endcase
                end
                OP_HOLD: begin
                    r_pk <= pk_new;
                    r_vl <= vl_new;
                end
                OP_HYST: begin
                    r_hyst        <= hyst_new;
                    r_beat_before <= r_beat_now;
                    r_beat_now    <= r_cond;
                end
                OP_BEAT: begin
                    r_ss      <= ss_new;
                    r_vl      <= VALLEY_FILL;
                    r_vl_time <= r_now;
                end
                OP_DIV_B: r_last_beat <= r_now;
                OP_BPM: begin
                    r_bpm   <= r_gap_zero ? BPM_NUM : r_div_q[15:0];
                    r_event <= EV_BEAT;
                end
                default: ;
            endcase
        end
    end

    assign o_status.filter   = !zero && !prime && !below_off && above_on;
    assign o_status.pto      = pto;
    assign o_status.vto      = vto;
    assign o_status.cond     = r_cond;
    assign o_status.rise     = !r_beat_before && r_beat_now;
    assign o_status.div_busy = (r_div_cnt != '0);
    assign o_data            = r_out;

endmodule

// File: sv/ppg_heartbeat_detector_top.sv
// Heartbeat detector for a three-channel optical pulse sensor. Each accepted
// reading produces exactly one result: event (0 none, 1 beat with bpm, 2 finger
// gone, 3 all-zero fault that clears the detector state), bpm and the current
// beat level. A reading handled before the filters (fault, priming, finger gone,
// total between the levels) goes from the pre-check straight to the output
// register; a filtered reading also passes up to six smoother updates, each a
// multiply, accumulate and write on the one shared multiplier, and, when a
// beat starts, one 25-step pass through the bit-serial bpm divider; the
// hysteresis size divides by fifteen with a reciprocal multiply. One reading
// is processed at a time; the next is taken while a result still waits in the
// output register. Configuration is written at any time the block is idle and
// the write channel is always ready.
module ppg_heartbeat_detector_top
    import ppg_pkg::*;
#(
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_s_tvalid,
    output logic                    o_s_tready,
    // red_level, ir_one_level, ir_two_level, now_ms, zero pad
    input  logic [((3 * SAMPLE_WIDTH + 32 + 7) / 8) * 8 - 1:0] i_s_tdata,
    output logic                    o_m_tvalid,
    input  logic                    i_m_tready,
    // event_res, beats_per_minute, beat_level, zero pad
    output logic [OUT_W-1:0]        o_m_tdata,
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [CFG_DATA_W-1:0]   i_cfg_data
);

    localparam int SW = SAMPLE_WIDTH;

    t_cmd    cmd;
    t_status status;

    ppg_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    ppg_dp #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_red_level    (i_s_tdata[SW-1:0]),
        .i_ir_one_level (i_s_tdata[2*SW-1:SW]),
        .i_ir_two_level (i_s_tdata[3*SW-1:2*SW]),
        .i_now_ms       (i_s_tdata[3*SW+31:3*SW]),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_cmd          (cmd),
        .o_status       (status),
        .o_data         (o_m_tdata)
    );

    assign o_cfg_ready = 1'b1;

endmodule

// File: test/tb.sv
module tb;
    import ppg_pkg::*;

    typedef struct {
        bit [15:0] red;
        bit [15:0] ir1;
        bit [15:0] ir2;
        bit [31:0] now;
    } t_reading;

    typedef struct {
        bit [1:0]  ev;
        bit [15:0] bpm;
        bit        beat;
    } t_outcome;

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_s_tvalid = 0;
    logic        o_s_tready;
    // red_level, ir_one_level, ir_two_level, now_ms
    logic [79:0] i_s_tdata = '0;
    logic        o_m_tvalid;
    logic        i_m_tready = 0;
    // event_res, beats_per_minute, beat_level, zero pad
    logic [23:0] o_m_tdata;
    logic        i_cfg_valid = 0;
    logic        o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    ppg_heartbeat_detector_top DUT (.*);

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // detector shadow: registers and state
    bit [17:0] on_lvl, off_lvl;
    bit [15:0] silence_ms, base_off;
    bit [4:0]  prime_n;
    bit [11:0] hmin, hmax;
    bit [17:0] prev_tot;
    bit [4:0]  fcount;
    longint    bl, hp, lp, hyst, pk_hold, vl_hold, sm_pk, sm_vl, sig_size;
    bit        beat_cur, beat_prev;
    bit [31:0] pk_t, vl_t, last_beat_t;

    t_reading  pending_q[$];
    t_reading  cur_item;
    t_outcome  expected_q[$];
    int        errors = 0;
    int        results_seen = 0;
    int        beats_seen = 0;
    int        faults_seen = 0;
    int        gone_seen = 0;
    int        burst_left = 0;
    int        gap_left = 0;
    int        hold_left = 0;
    bit        hold_done = 0;
    int        stall_mode = 0;
    longint    cycles = 0;
    bit        stim_done = 0;

    function automatic longint clip32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint round16(longint v);
        v = v + 32768;
        if (v >= 0) return v >>> 16;
        return -(((-v) + 65535) >>> 16);
    endfunction

    function automatic longint ema(longint x, longint s, longint a);
        return clip32(round16(x * (65536 - a) + s * a));
    endfunction

    function automatic longint q8_whole(longint d);
        if (d >= 0) return d >>> 8;
        return -((-d) >>> 8);
    endfunction

    function automatic void clear_detector();
        prev_tot = 0; fcount = 0;
        bl = 0; hp = 0; lp = 0; hyst = 0;
        pk_hold = 0; vl_hold = 0; sm_pk = 0; sm_vl = 0; sig_size = 0;
        beat_cur = 0; beat_prev = 0;
        pk_t = 0; vl_t = 0; last_beat_t = 0;
    endfunction

    function automatic void write_reg(bit [CFG_IDX_W-1:0] idx, bit [CFG_DATA_W-1:0] val);
        case (idx)
            REG_FINGER_ON:  on_lvl = val;
            REG_FINGER_OFF: off_lvl = val;
            REG_TIMEOUT:    silence_ms = val[15:0];
            REG_PRIME:      prime_n = val[4:0];
            REG_OFFSET:     base_off = val[15:0];
            REG_HYST_MIN:   hmin = val[11:0];
            REG_HYST_MAX:   hmax = val[11:0];
            default: ;
        endcase
    endfunction

    function automatic t_outcome detect_beat(t_reading r);
        t_outcome  o;
        bit [17:0] tot;
        longint    x, hp2, shifted, h;
        bit [31:0] gap;
        o.ev = EV_NONE; o.bpm = 0; o.beat = 0;
        if (r.red == 0 && r.ir1 == 0 && r.ir2 == 0) begin
            clear_detector();
            o.ev = EV_FAULT;
            return o;
        end
        if (pk_t == 0) pk_t = r.now;
        if (vl_t == 0) vl_t = r.now;
        tot = 18'(r.red) + r.ir1 + r.ir2;
        if (prev_tot < on_lvl && tot > on_lvl) fcount = 1;
        prev_tot = tot;
        fcount = fcount + 5'd1;
        if (fcount > COUNT_CAP) fcount = COUNT_CAP;
        if (fcount < prime_n) begin
            bl = clip32((longint'(tot) - longint'(base_off)) * 256);
        end else if (tot < off_lvl) begin
            o.ev = EV_GONE;
        end else if (tot > on_lvl) begin
            x = (longint'(r.ir1) + longint'(r.ir2)) * 256;
            bl = ema(x, bl, K99);
            hp = ema(clip32(x - bl), hp, K20);
            hp2 = hp + hyst * 256;
            lp = ema(clip32(x - bl), lp, K95);
            shifted = lp - round16(sig_size * 256 * longint'(K05));
            if (pk_hold == 0 || hp > pk_hold) pk_hold = hp;
            if (r.now - pk_t > 32'(silence_ms)) begin
                sm_pk = ema(pk_hold, sm_pk, K60);
                pk_hold = 0;
                pk_t = r.now;
            end
            if (vl_hold == 0 || hp < vl_hold) vl_hold = hp;
            if (r.now - vl_t > 32'(silence_ms)) begin
                sm_vl = ema(vl_hold, sm_vl, K60);
                vl_hold = 0;
                vl_t = r.now;
            end
            h = sig_size / 15;
            if (h < longint'(hmin)) h = hmin;
            else if (h > longint'(hmax)) h = hmax;
            hyst = h;
            beat_prev = beat_cur;
            if (hp2 < shifted) begin
                beat_cur = 1;
                hyst = -hyst;
                sm_vl = ema(vl_hold, sm_vl, K99);
                sig_size = q8_whole(sm_pk - sm_vl);
                vl_hold = longint'(VALLEY_FILL);
                vl_t = r.now;
            end else begin
                beat_cur = 0;
                sm_pk = ema(pk_hold, sm_pk, K99);
                pk_hold = 0;
                pk_t = r.now;
            end
            if (!beat_prev && beat_cur) begin
                gap = r.now - last_beat_t;
                last_beat_t = r.now;
                o.bpm = (gap == 0) ? BPM_NUM : 16'(32'(BPM_NUM) / gap);
                o.ev = EV_BEAT;
            end
        end
        o.beat = beat_cur;
        return o;
    endfunction

    // reading driver: bursts with random gaps
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 0;
        end else begin
            if (i_s_tvalid && o_s_tready) begin
                expected_q.push_back(detect_beat(cur_item));
            end
            if (!(i_s_tvalid && !o_s_tready)) begin
                if (gap_left > 0) begin
                    gap_left = gap_left - 1;
                    i_s_tvalid <= 0;
                end else if (pending_q.size() > 0) begin
                    cur_item = pending_q.pop_front();
                    i_s_tvalid <= 1;
                    i_s_tdata <= {cur_item.now, cur_item.ir2, cur_item.ir1, cur_item.red};
                    if (burst_left > 0) begin
                        burst_left = burst_left - 1;
                    end else begin
                        burst_left = $urandom_range(0, 20);
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
                    end
                end else begin
                    i_s_tvalid <= 0;
                end
            end
        end
    end

    // result receiver stall pattern
    always @(posedge i_clk) begin
        cycles = cycles + 1;
        if (!i_rst_n) begin
            i_m_tready <= 0;
        end else if (hold_left > 0) begin
            hold_left = hold_left - 1;
            i_m_tready <= 0;
        end else if (!hold_done && results_seen >= 300) begin
            hold_done = 1;
            hold_left = 2000;
            i_m_tready <= 0;
        end else begin
            if ($urandom_range(0, 99) == 0) stall_mode = $urandom_range(0, 2);
            case (stall_mode)
                0: i_m_tready <= 1;
                1: i_m_tready <= ($urandom_range(0, 3) != 0);
                default: i_m_tready <= ($urandom_range(0, 7) == 0);
            endcase
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_outcome e;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            results_seen = results_seen + 1;
            if (o_m_tdata[1:0] == EV_BEAT) beats_seen = beats_seen + 1;
            if (o_m_tdata[1:0] == EV_FAULT) faults_seen = faults_seen + 1;
            if (o_m_tdata[1:0] == EV_GONE) gone_seen = gone_seen + 1;
            if (expected_q.size() == 0) begin
                $error("unexpected result transaction %h", o_m_tdata);
                errors = errors + 1;
            end else begin
                e = expected_q.pop_front();
                if (o_m_tdata[1:0] != e.ev) begin
                    $error("event_res expected %0d actual %0d", e.ev, o_m_tdata[1:0]);
                    errors = errors + 1;
                end
                if (o_m_tdata[17:2] != e.bpm) begin
                    $error("beats_per_minute expected %0d actual %0d", e.bpm, o_m_tdata[17:2]);
                    errors = errors + 1;
                end
                if (o_m_tdata[18] != e.beat) begin
                    $error("beat_level expected %0d actual %0d", e.beat, o_m_tdata[18]);
                    errors = errors + 1;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (cycles > 3000000) begin
            $display("timeout with %0d results outstanding", expected_q.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic cfg_write(bit [CFG_IDX_W-1:0] idx, bit [CFG_DATA_W-1:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        write_reg(idx, val);
        i_cfg_valid <= 0;
    endtask

    task automatic add_item(int red, int ir1, int ir2, bit [31:0] now);
        t_reading r;
        r.red = 16'(red); r.ir1 = 16'(ir1); r.ir2 = 16'(ir2); r.now = now;
        pending_q.push_back(r);
    endtask

    // finger placed, then a sawtooth pulse with a sharp drop each period
    task automatic add_session(int n);
        bit [31:0] t;
        int base, amp, per, ph, v, red, k;
        t = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FF00 + $urandom_range(0, 200)
                                         : $urandom_range(0, 100000);
        base = $urandom_range(20000, 100000);
        amp = $urandom_range(100, 4000);
        per = $urandom_range(400, 1500);
        red = $urandom_range(2000, 30000);
        if ($urandom_range(0, 2) == 0) add_item(10, 10, 10, t);
        for (k = 0; k < n; k++) begin
            t = t + $urandom_range(5, 15);
            ph = t % per;
            if (ph < per * 4 / 5) v = base + amp * ph / (per * 4 / 5);
            else v = base + amp - amp * (ph - per * 4 / 5) / (per / 5 + 1);
            v = v + $urandom_range(0, amp / 20 + 1);
            if (v > 131070) v = 131070;
            add_item(red, v / 2, v - v / 2, t);
        end
        if ($urandom_range(0, 1) == 0) add_item(100, 100, 100, t + 10);
    endtask

    task automatic add_noise(int n);
        int k, m;
        for (k = 0; k < n; k++) begin
            m = $urandom_range(0, 9);
            if (m == 0) add_item(0, 0, 0, $urandom);
            else if (m < 5) add_item($urandom_range(0, 65535), $urandom_range(0, 65535),
                                     $urandom_range(0, 65535), $urandom);
            else add_item($urandom_range(0, 3000), $urandom_range(0, 3000),
                          $urandom_range(0, 3000), $urandom);
        end
    endtask

    task automatic run_phase(int sessions);
        int s;
        for (s = 0; s < sessions; s++) add_session($urandom_range(40, 120));
        add_noise(12);
        @(posedge i_clk);
        while (pending_q.size() != 0 || i_s_tvalid || expected_q.size() != 0)
            @(posedge i_clk);
        repeat (120) @(posedge i_clk);
    endtask

    task automatic cfg_all(int on, int off, int to, int pr, int ofs, int mn, int mx);
        cfg_write(REG_FINGER_ON, CFG_DATA_W'(on));
        cfg_write(REG_FINGER_OFF, CFG_DATA_W'(off));
        cfg_write(REG_TIMEOUT, CFG_DATA_W'(to));
        cfg_write(REG_PRIME, CFG_DATA_W'(pr));
        cfg_write(REG_OFFSET, CFG_DATA_W'(ofs));
        cfg_write(REG_HYST_MIN, CFG_DATA_W'(mn));
        cfg_write(REG_HYST_MAX, CFG_DATA_W'(mx));
    endtask

    initial begin
        on_lvl = FINGER_ON_RST; off_lvl = FINGER_OFF_RST; silence_ms = TIMEOUT_RST;
        prime_n = PRIME_RST; base_off = OFFSET_RST; hmin = HYST_MIN_RST;
        hmax = HYST_MAX_RST;
        clear_detector();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1;
        // directed: fault, extremes, gone, between levels, zero interval
        add_item(0, 0, 0, 0);
        add_item(65535, 65535, 65535, 32'hFFFF_FFFF);
        add_item(65535, 65535, 65535, 0);
        add_item(1, 0, 0, 1);
        add_item(0, 1, 0, 2);
        add_item(0, 0, 1, 3);
        add_item(16'hAAAA, 16'h5555, 16'hAAAA, 32'h5555_5555);
        add_item(16'h5555, 16'hAAAA, 16'h5555, 32'hAAAA_AAAA);
        add_item(100, 100, 100, 10);
        add_item(5000, 5000, 5000, 20);
        add_item(0, 0, 0, 30);
        add_noise(8);
        run_phase(1);
        cfg_all(20000, 5000, 1800, 5, 200, 35, 120);
        run_phase(1);
        cfg_all(0, 0, 0, 0, 0, 0, 0);
        run_phase(1);
        cfg_all(196605, 196605, 65535, 25, 65535, 4095, 4095);
        run_phase(1);
        cfg_all(30000, 1000, 500, 31, 1000, 1, 2);
        run_phase(1);
        cfg_all(15000, 8000, 3000, 1, 1000, 200, 10);
        run_phase(2);
        cfg_all(25000, 4000, 2500, 12, 300, 20, 4095);
        run_phase(2);
        $display("checked %0d results over 7 register settings", results_seen);
        $display("beats %0d, finger gone %0d, faults %0d", beats_seen, gone_seen, faults_seen);
        if (errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end
endmodule

// File: sim.f
+incdir+sv
sv/ppg_pkg.sv
sv/ppg_ctrl.sv
sv/ppg_dp.sv
sv/ppg_heartbeat_detector_top.sv
test/tb.sv
